### src/range_row_edge_detector_top_macros.svh
// ----------------------------------------------------------------------------
// Range-row edge detector assertion macros
// Shared assertion wrappers; define NO_ASSERTIONS to compile them away.
// ----------------------------------------------------------------------------
`ifndef RANGE_ROW_EDGE_DETECTOR_TOP_MACROS_SVH
`define RANGE_ROW_EDGE_DETECTOR_TOP_MACROS_SVH
`ifndef NO_ASSERTIONS
// Same-cycle implication, sampled on clk and disabled during reset.
`define RRED_ASSERT_IMPLY(lbl, ante, cons) \
lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
	else $error("rred assertion failed");
// Next-cycle implication, sampled on clk and disabled during reset.
`define RRED_ASSERT_NEXT(lbl, ante, cons) \
lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
	else $error("rred assertion failed");
`else
`define RRED_ASSERT_IMPLY(lbl, ante, cons)
`define RRED_ASSERT_NEXT(lbl, ante, cons)
`endif
`endif

### src/rred_pkg.sv
// ----------------------------------------------------------------------------
// Range-row edge detector package
// Widths, register indexes, job record and state types shared by the block.
// ----------------------------------------------------------------------------
package rred_pkg;

	localparam int HALF_WINDOW   = 8;
	localparam int FRACTION_BITS = 8;
	localparam int MAX_COLUMNS   = 4096;
	localparam int WIN_LEN       = 2 * HALF_WINDOW + 1;
	localparam int RANGE_LEN     = HALF_WINDOW + 1;
	localparam int WIN_DIVISOR   = 2 * HALF_WINDOW;
	localparam int DIV_SHIFT     = 4;
	localparam int SCORE_SHIFT   = 2 * FRACTION_BITS;

	localparam int RANGE_W  = 16;
	localparam int ROW_W    = 10;
	localparam int COL_W    = 12;
	localparam int CNT_W    = 13;
	localparam int SCORE_W  = 31;
	localparam int DIFF_W   = 25;
	localparam int SQ_W     = 48;
	localparam int SUM_W    = 30;
	localparam int SUMSQ_W  = 53;
	localparam int MEAN_W   = 26;
	localparam int DEV_W    = 27;
	localparam int MUL_W    = 31;
	localparam int PROD_W   = 2 * MUL_W;
	localparam int SQSUM_W  = 58;
	localparam int VAR_W    = SQSUM_W - DIV_SHIFT;
	localparam int NUM_W    = 52;
	localparam int REM_W    = VAR_W + 1;
	localparam int DCNT_W   = 6;
	localparam int QUEUE_DEPTH = 2;

	// Configuration port.
	localparam int CFG_IDX_W  = 1;
	localparam int CFG_DATA_W = 31;
	localparam logic [CFG_IDX_W-1:0] CFG_THRESHOLD = 1'b0;
	localparam logic [CFG_IDX_W-1:0] CFG_COLUMNS   = 1'b1;
	localparam logic [CNT_W-1:0] COLUMNS_RESET = 13'd1024;

	// One scored pixel handed from the front to the back.
	typedef struct packed {
		logic [ROW_W-1:0]          row;
		logic [COL_W-1:0]          column;
		logic [RANGE_W-1:0]        centre;
		logic signed [SUM_W-1:0]   sum;
		logic [SUMSQ_W-1:0]        sumsq;
	} rred_job_t;

	typedef enum logic [1:0] {
		FR_IDLE, FR_SQUARE, FR_ACCUM, FR_PUSH
	} rred_front_state_t;

	typedef enum logic [2:0] {
		BK_IDLE, BK_MEAN, BK_PROD1, BK_PROD2, BK_VAR, BK_DEV, BK_DIV, BK_FIN
	} rred_back_state_t;

endpackage

### src/rred_if.sv
// ----------------------------------------------------------------------------
// Range-row edge detector stream interfaces
// Valid/ready channels for incoming range words and outgoing edge words.
// ----------------------------------------------------------------------------
interface rred_in_if;
	import rred_pkg::*;
	logic               valid;
	logic               ready;
	logic [RANGE_W-1:0] range_sample;
	logic               frame_start;
	modport source (output valid, range_sample, frame_start, input ready);
	modport sink (input valid, range_sample, frame_start, output ready);
endinterface

interface rred_out_if;
	import rred_pkg::*;
	logic               valid;
	logic               ready;
	logic [ROW_W-1:0]   edge_row;
	logic [COL_W-1:0]   edge_column;
	logic [SCORE_W-1:0] edge_score;
	modport source (output valid, edge_row, edge_column, edge_score, input ready);
	modport sink (input valid, edge_row, edge_column, edge_score, output ready);
endinterface

### src/rred_front.sv
// ----------------------------------------------------------------------------
// Range-row edge detector front end
// Tracks row and column, slides the difference window and keeps running sums.
// ----------------------------------------------------------------------------
module rred_front import rred_pkg::*; (
	input  logic             clk,
	input  logic             arst_n,
	input  logic [CNT_W-1:0] columns_in_use,
	rred_in_if.sink          in_ch,
	output rred_job_t        push_data,
	output logic             push_valid,
	input  logic             push_ready
);

	rred_front_state_t state_q, state_d;

	logic signed [DIFF_W-1:0] win_q [WIN_LEN];
	logic [RANGE_W-1:0]       rng_q [RANGE_LEN];
	logic [RANGE_W-1:0]       prev_q;
	logic [CNT_W-1:0]         colcnt_q;
	logic [ROW_W-1:0]         rowcnt_q;
	logic signed [SUM_W-1:0]  sum_q;
	logic [SUMSQ_W-1:0]       sumsq_q;
	logic signed [DIFF_W-1:0] dnew_q, dold_q;
	logic [SQ_W-1:0]          sqn_q, sqo_q;
	logic                     scored_q;
	logic [ROW_W-1:0]         row_q;
	logic [COL_W-1:0]         column_q;
	logic [RANGE_W-1:0]       centre_q;

	logic                     accept;
	logic [CNT_W-1:0]         cols_c, colb_c, col_c, coln_c;
	logic [ROW_W-1:0]         rowb_c, row_c, rown_c;
	logic signed [RANGE_W:0]  rdiff_c;
	logic signed [DIFF_W-1:0] diff_c;
	logic signed [2*DIFF_W-1:0] sqn_c, sqo_c;

	assign accept = in_ch.valid && in_ch.ready;

	// Clamp the row length and place the arriving word in the frame.
	always_comb begin
		if (columns_in_use == '0) begin
			cols_c = CNT_W'(1);
		end else if (columns_in_use > CNT_W'(MAX_COLUMNS)) begin
			cols_c = CNT_W'(MAX_COLUMNS);
		end else begin
			cols_c = columns_in_use;
		end
		colb_c = in_ch.frame_start ? '0 : colcnt_q;
		rowb_c = in_ch.frame_start ? '0 : rowcnt_q;
		if (colb_c >= cols_c) begin
			col_c = '0;
			row_c = rowb_c + ROW_W'(1);
		end else begin
			col_c = colb_c;
			row_c = rowb_c;
		end
		if (col_c + CNT_W'(1) >= cols_c) begin
			coln_c = '0;
			rown_c = row_c + ROW_W'(1);
		end else begin
			coln_c = col_c + CNT_W'(1);
			rown_c = row_c;
		end
		rdiff_c = $signed({1'b0, in_ch.range_sample}) - $signed({1'b0, prev_q});
		diff_c  = (col_c == '0) ? '0 : {rdiff_c, {FRACTION_BITS{1'b0}}};
	end

	assign sqn_c = dnew_q * dnew_q;
	assign sqo_c = dold_q * dold_q;

	// Next-state logic.
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			FR_IDLE:   if (accept) state_d = FR_SQUARE;
			FR_SQUARE: state_d = FR_ACCUM;
			FR_ACCUM:  state_d = FR_PUSH;
			FR_PUSH:   if (!scored_q || push_ready) state_d = FR_IDLE;
			default:   state_d = FR_IDLE;
		endcase
	end

	// Output logic.
	always_comb begin
		in_ch.ready = 1'b0;
		push_valid  = 1'b0;
		unique case (state_q)
			FR_IDLE: in_ch.ready = 1'b1;
			FR_PUSH: push_valid = scored_q;
			default: ;
		endcase
	end

	assign push_data = '{row: row_q, column: column_q, centre: centre_q,
		sum: sum_q, sumsq: sumsq_q};

	// Control state and window contents.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= FR_IDLE;
			prev_q   <= '0;
			colcnt_q <= '0;
			rowcnt_q <= '0;
			sum_q    <= '0;
			sumsq_q  <= '0;
			for (int k = 0; k < WIN_LEN; k++) win_q[k] <= '0;
			for (int k = 0; k < RANGE_LEN; k++) rng_q[k] <= '0;
		end else begin
			state_q <= state_d;
			if (accept) begin
				prev_q   <= in_ch.range_sample;
				colcnt_q <= coln_c;
				rowcnt_q <= rown_c;
				for (int k = 0; k < WIN_LEN - 1; k++) win_q[k] <= win_q[k+1];
				win_q[WIN_LEN-1] <= diff_c;
				for (int k = 0; k < RANGE_LEN - 1; k++) rng_q[k] <= rng_q[k+1];
				rng_q[RANGE_LEN-1] <= in_ch.range_sample;
			end
			if (state_q == FR_ACCUM) begin
				sum_q   <= sum_q + SUM_W'(dnew_q) - SUM_W'(dold_q);
				sumsq_q <= sumsq_q + SUMSQ_W'(sqn_q) - SUMSQ_W'(sqo_q);
			end
		end
	end

	// Per-word working registers.
	always_ff @(posedge clk) begin
		if (accept) begin
			dnew_q   <= diff_c;
			dold_q   <= win_q[0];
			scored_q <= (col_c >= CNT_W'(WIN_LEN));
			row_q    <= row_c;
			column_q <= COL_W'(col_c - CNT_W'(HALF_WINDOW));
			centre_q <= rng_q[1];
		end
		if (state_q == FR_SQUARE) begin
			sqn_q <= sqn_c[SQ_W-1:0];
			sqo_q <= sqo_c[SQ_W-1:0];
		end
	end

endmodule

### src/rred_fifo.sv
// ----------------------------------------------------------------------------
// Range-row edge detector job queue
// Short queue that decouples the front end from the scoring back end.
// ----------------------------------------------------------------------------
module rred_fifo import rred_pkg::*; (
	input  logic      clk,
	input  logic      arst_n,
	input  rred_job_t push_data,
	input  logic      push_valid,
	output logic      push_ready,
	output rred_job_t pop_data,
	output logic      pop_valid,
	input  logic      pop
);

	localparam int PTR_W = $clog2(QUEUE_DEPTH);

	rred_job_t          mem_q [QUEUE_DEPTH];
	logic [PTR_W-1:0]   wr_q, rd_q;
	logic [PTR_W:0]     cnt_q;
	logic               do_push, do_pop;

	assign push_ready = (cnt_q != (PTR_W+1)'(QUEUE_DEPTH));
	assign pop_valid  = (cnt_q != '0);
	assign do_push    = push_valid && push_ready;
	assign do_pop     = pop && pop_valid;
	assign pop_data   = mem_q[rd_q];

	// Storage.
	always_ff @(posedge clk) begin
		if (do_push) mem_q[wr_q] <= push_data;
	end

	// Pointers and fill count.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= '0;
			rd_q  <= '0;
			cnt_q <= '0;
		end else begin
			if (do_push) wr_q <= wr_q + PTR_W'(1);
			if (do_pop) rd_q <= rd_q + PTR_W'(1);
			cnt_q <= cnt_q + (PTR_W+1)'(do_push) - (PTR_W+1)'(do_pop);
		end
	end

endmodule

### src/rred_back.sv
// ----------------------------------------------------------------------------
// Range-row edge detector back end
// Mean, variance and score of one job on a shared multiplier and a radix-2
// divider, then the threshold test and the output register.
// ----------------------------------------------------------------------------
`include "range_row_edge_detector_top_macros.svh"
module rred_back import rred_pkg::*; (
	input  logic               clk,
	input  logic               arst_n,
	input  logic [SCORE_W-1:0] edge_threshold,
	input  rred_job_t          job,
	input  logic               job_valid,
	output logic               job_pop,
	rred_out_if.source         out_ch
);

	rred_back_state_t state_q, state_d;

	rred_job_t                  job_q;
	logic signed [MEAN_W-1:0]   mean_q;
	logic signed [PROD_W-1:0]   p1_q, p2_q;
	logic [VAR_W-1:0]           var_q;
	logic [REM_W-1:0]           rem_q;
	logic [NUM_W-1:0]           quo_q;
	logic [DCNT_W-1:0]          div_cnt_q;
	logic                       out_valid_q;
	logic [ROW_W-1:0]           out_row_q;
	logic [COL_W-1:0]           out_col_q;
	logic [SCORE_W-1:0]         out_score_q;

	logic signed [SUM_W-1:0]    sum_adj_c;
	logic signed [MUL_W-1:0]    mul_a, mul_b;
	logic signed [PROD_W-1:0]   prod_c;
	logic signed [DEV_W-1:0]    dev_c;
	logic signed [SQSUM_W-1:0]  sq_c, p2x_c;
	logic [REM_W-1:0]           trial_c;
	logic                       fit_c;
	logic [NUM_W-SCORE_SHIFT-1:0] qshift_c;
	logic [SCORE_W-1:0]         score_c;
	logic                       hit_c, out_load;

	// Mean with truncation toward zero.
	assign sum_adj_c = job_q.sum + (job_q.sum[SUM_W-1] ? SUM_W'(WIN_DIVISOR - 1) : '0);
	assign dev_c = $signed({3'b000, job_q.centre, {FRACTION_BITS{1'b0}}}) - DEV_W'(mean_q);

	// Shared multiplier operands.
	always_comb begin
		mul_a = MUL_W'(mean_q);
		mul_b = MUL_W'(job_q.sum);
		case (state_q)
			BK_PROD2: mul_b = MUL_W'(mean_q);
			BK_DEV: begin
				mul_a = MUL_W'(dev_c);
				mul_b = MUL_W'(dev_c);
			end
			default: ;
		endcase
	end
	assign prod_c = mul_a * mul_b;

	// Sum of squared deviations from the running sums.
	assign p2x_c = SQSUM_W'(p2_q);
	assign sq_c  = SQSUM_W'($signed({1'b0, job_q.sumsq})) - (SQSUM_W'(p1_q) <<< 1)
		+ (p2x_c <<< 4) + p2x_c;

	// One quotient bit per cycle.
	assign trial_c = {rem_q[REM_W-2:0], quo_q[NUM_W-1]};
	assign fit_c   = (trial_c >= {1'b0, var_q});

	// Score scaling and saturation.
	always_comb begin
		qshift_c = quo_q[NUM_W-1:SCORE_SHIFT];
		if (qshift_c[NUM_W-SCORE_SHIFT-1:SCORE_W] != '0) begin
			score_c = '1;
		end else begin
			score_c = qshift_c[SCORE_W-1:0];
		end
		hit_c = (score_c > edge_threshold);
	end

	// Next-state logic.
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			BK_IDLE:  if (job_valid) state_d = BK_MEAN;
			BK_MEAN:  state_d = BK_PROD1;
			BK_PROD1: state_d = BK_PROD2;
			BK_PROD2: state_d = BK_VAR;
			BK_VAR:   state_d = BK_DEV;
			BK_DEV:   state_d = (var_q == '0) ? BK_IDLE : BK_DIV;
			BK_DIV:   if (div_cnt_q == DCNT_W'(NUM_W - 1)) state_d = BK_FIN;
			BK_FIN:   if (!hit_c || !out_valid_q || out_ch.ready) state_d = BK_IDLE;
			default:  state_d = BK_IDLE;
		endcase
	end

	// Output logic.
	always_comb begin
		job_pop  = 1'b0;
		out_load = 1'b0;
		unique case (state_q)
			BK_IDLE: job_pop = job_valid;
			BK_FIN:  out_load = hit_c && (!out_valid_q || out_ch.ready);
			default: ;
		endcase
	end

	assign out_ch.valid       = out_valid_q;
	assign out_ch.edge_row    = out_row_q;
	assign out_ch.edge_column = out_col_q;
	assign out_ch.edge_score  = out_score_q;

	// Control state.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= BK_IDLE;
			out_valid_q <= 1'b0;
			div_cnt_q   <= '0;
		end else begin
			state_q <= state_d;
			if (out_load) begin
				out_valid_q <= 1'b1;
			end else if (out_ch.ready) begin
				out_valid_q <= 1'b0;
			end
			if (state_q == BK_DIV) begin
				div_cnt_q <= div_cnt_q + DCNT_W'(1);
			end else begin
				div_cnt_q <= '0;
			end
		end
	end

	// Datapath registers.
	always_ff @(posedge clk) begin
		if (job_pop) job_q <= job;
		if (state_q == BK_MEAN) mean_q <= MEAN_W'(sum_adj_c >>> DIV_SHIFT);
		if (state_q == BK_PROD1) p1_q <= prod_c;
		if (state_q == BK_PROD2) p2_q <= prod_c;
		if (state_q == BK_VAR) var_q <= sq_c[SQSUM_W-1:DIV_SHIFT];
		if (state_q == BK_DEV) begin
			rem_q <= '0;
			quo_q <= prod_c[NUM_W-1:0];
		end
		if (state_q == BK_DIV) begin
			rem_q <= fit_c ? (trial_c - {1'b0, var_q}) : trial_c;
			quo_q <= {quo_q[NUM_W-2:0], fit_c};
		end
		if (out_load) begin
			out_row_q   <= job_q.row;
			out_col_q   <= job_q.column;
			out_score_q <= score_c;
		end
	end

	`RRED_ASSERT_IMPLY(a_pop_only_idle, job_pop, state_q == BK_IDLE)
	`RRED_ASSERT_IMPLY(a_div_count_bound, state_q == BK_DIV, div_cnt_q < DCNT_W'(NUM_W))
	`RRED_ASSERT_NEXT(a_load_shows_word, out_load, out_valid_q)

endmodule

### src/range_row_edge_detector_top.sv
// ----------------------------------------------------------------------------
// Range-row edge detector top level
// Configuration registers and the front end, job queue and back end.
// ----------------------------------------------------------------------------
// The front end takes one range word at a time (accept, square the entering
// and leaving differences, update the running sums, hand off) and takes no
// new word until the hand-off is done, which waits while the job queue is
// full. Each pixel that can be scored then occupies the back end mainly in
// the bit-serial divider, which produces one of 52 quotient bits per cycle; a
// two-entry job queue lets the front keep taking words meanwhile. Results are
// held in an output register and appear in input order.
module range_row_edge_detector_top import rred_pkg::*; (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  cfg_write,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_data,
	rred_in_if.sink               in_ch,
	rred_out_if.source            out_ch
);

	logic [SCORE_W-1:0] threshold_q;
	logic [CNT_W-1:0]   columns_q;
	rred_job_t          push_data, pop_data;
	logic               push_valid, push_ready, pop_valid, pop;

	// Configuration registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			threshold_q <= '0;
			columns_q   <= COLUMNS_RESET;
		end else if (cfg_write) begin
			unique case (cfg_index)
				CFG_THRESHOLD: threshold_q <= cfg_data[SCORE_W-1:0];
				CFG_COLUMNS:   columns_q   <= cfg_data[CNT_W-1:0];
				default: ;
			endcase
		end
	end

	rred_front u_front (
		.clk(clk), .arst_n(arst_n), .columns_in_use(columns_q), .in_ch(in_ch),
		.push_data(push_data), .push_valid(push_valid), .push_ready(push_ready)
	);

	rred_fifo u_fifo (
		.clk(clk), .arst_n(arst_n), .push_data(push_data), .push_valid(push_valid),
		.push_ready(push_ready), .pop_data(pop_data), .pop_valid(pop_valid), .pop(pop)
	);

	rred_back u_back (
		.clk(clk), .arst_n(arst_n), .edge_threshold(threshold_q), .job(pop_data),
		.job_valid(pop_valid), .job_pop(pop), .out_ch(out_ch)
	);

endmodule

### sim/tb_range_row_edge_detector_top.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Range-row edge detector testbench
// Streams range words through the block under several column and threshold
// settings, predicts each edge word and checks every word the block returns.
// ----------------------------------------------------------------------------
module tb_range_row_edge_detector_top;
	import rred_pkg::*;

	localparam int  CLK_HALF   = 10;
	localparam int  QUIET_WAIT = 300;
	localparam longint CYCLE_LIMIT = 4000000;

	typedef struct {
		bit [ROW_W-1:0]   row;
		bit [COL_W-1:0]   column;
		bit [SCORE_W-1:0] score;
	} edge_word_t;

	// Scoreboard: keeps its own copy of the detector state and the expected
	// edge words in arrival order.
	class edge_scoreboard;
		longint          diffs[WIN_LEN];
		int unsigned     ranges[RANGE_LEN];
		int unsigned     last_range;
		int unsigned     col_count;
		int unsigned     row_count;
		longint unsigned threshold;
		int unsigned     columns;
		edge_word_t      pending[$];
		int              failures;

		function new();
			foreach (diffs[k]) diffs[k] = 0;
			foreach (ranges[k]) ranges[k] = 0;
			last_range = 0;
			col_count  = 0;
			row_count  = 0;
			threshold  = 0;
			columns    = COLUMNS_RESET;
			failures   = 0;
		endfunction

		function void write_register(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
			if (idx == CFG_THRESHOLD)
				threshold = data;
			else if (idx == CFG_COLUMNS)
				columns = data & 32'h1FFF;
		endfunction

		// Notes one accepted range word and queues the edge word it causes.
		function void note_word(bit [RANGE_W-1:0] r, bit fs);
			int unsigned     cols;
			int unsigned     col;
			longint          diff;
			longint          sum;
			longint          mean;
			longint          dev;
			longint unsigned sq_sum;
			longint unsigned variance;
			longint unsigned score;
			edge_word_t      w;
			cols = columns;
			if (cols < 1) cols = 1;
			if (cols > MAX_COLUMNS) cols = MAX_COLUMNS;
			if (fs) begin
				col_count = 0;
				row_count = 0;
			end
			if (col_count >= cols) begin
				col_count = 0;
				row_count = (row_count + 1) % 1024;
			end
			col = col_count;
			diff = (col == 0) ? 0 : (longint'(r) - longint'(last_range)) * (1 << FRACTION_BITS);
			last_range = r;
			for (int k = 0; k < WIN_LEN - 1; k++) diffs[k] = diffs[k+1];
			diffs[WIN_LEN-1] = diff;
			for (int k = 0; k < RANGE_LEN - 1; k++) ranges[k] = ranges[k+1];
			ranges[RANGE_LEN-1] = r;
			if (col >= WIN_LEN) begin
				sum = 0;
				foreach (diffs[k]) sum += diffs[k];
				mean = sum / WIN_DIVISOR;
				sq_sum = 0;
				foreach (diffs[k]) begin
					dev = diffs[k] - mean;
					sq_sum += longint'(dev * dev);
				end
				variance = sq_sum / WIN_DIVISOR;
				if (variance != 0) begin
					dev = longint'(ranges[0]) * (1 << FRACTION_BITS) - mean;
					score = longint'(dev * dev);
					score = (score / variance) >> SCORE_SHIFT;
					if (score > 64'h7FFF_FFFF) score = 64'h7FFF_FFFF;
					if (score > threshold) begin
						w.row    = row_count[ROW_W-1:0];
						w.column = COL_W'(col - HALF_WINDOW);
						w.score  = score[SCORE_W-1:0];
						pending.push_back(w);
					end
				end
			end
			if (col + 1 >= cols) begin
				col_count = 0;
				row_count = (row_count + 1) % 1024;
			end else begin
				col_count = col + 1;
			end
		endfunction

		// Compares one returned edge word with the oldest expectation.
		function void check_word(bit [ROW_W-1:0] row, bit [COL_W-1:0] column,
				bit [SCORE_W-1:0] score);
			edge_word_t w;
			if (pending.size() == 0) begin
				$error("unexpected edge word row=%0d column=%0d score=%0d", row, column, score);
				failures++;
				return;
			end
			w = pending.pop_front();
			if (w.row != row) begin
				$error("edge_row: expected %0d, actual %0d", w.row, row);
				failures++;
			end
			if (w.column != column) begin
				$error("edge_column: expected %0d, actual %0d", w.column, column);
				failures++;
			end
			if (w.score != score) begin
				$error("edge_score: expected %0d, actual %0d", w.score, score);
				failures++;
			end
		endfunction
	endclass

	logic                  clk;
	logic                  arst_n;
	logic                  cfg_write;
	logic [CFG_IDX_W-1:0]  cfg_index;
	logic [CFG_DATA_W-1:0] cfg_data;

	rred_in_if  in_bus();
	rred_out_if out_bus();

	range_row_edge_detector_top dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg_write(cfg_write),
		.cfg_index(cfg_index),
		.cfg_data (cfg_data),
		.in_ch    (in_bus.sink),
		.out_ch   (out_bus.source)
	);

	edge_scoreboard scoreboard = new();
	longint cycle_count = 0;
	int     words_sent  = 0;
	bit     idle_free   = 0;
	int     walk_value  = 30000;

	// Clock and run limit.
	initial clk = 1'b0;
	always #CLK_HALF clk = ~clk;

	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("tb_range_row_edge_detector_top: FAIL");
			$finish;
		end
	end

	// Mostly short gaps, a few long ones; none while idle_free is set.
	function automatic int gap_length();
		int pick;
		if (idle_free) return 0;
		pick = $urandom_range(0, 99);
		if (pick < 60) return 0;
		if (pick < 92) return $urandom_range(1, 3);
		return $urandom_range(10, 40);
	endfunction

	// Smooth range profile with jumps, plus pure noise now and then.
	function automatic bit [RANGE_W-1:0] next_range();
		int pick;
		pick = $urandom_range(0, 99);
		if (pick < 8)
			return RANGE_W'($urandom);
		if (pick < 12)
			walk_value = $urandom_range(0, 65535);
		else
			walk_value = walk_value + $urandom_range(0, 16) - 8;
		if (walk_value < 0) walk_value = 0;
		if (walk_value > 65535) walk_value = 65535;
		return RANGE_W'(walk_value);
	endfunction

	// One register write; returns once the write enable has dropped.
	task automatic write_register(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
		cfg_write <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= data;
		@(posedge clk);
		cfg_write <= 1'b0;
		scoreboard.write_register(idx, data);
		@(posedge clk);
	endtask

	// Offers one word and returns once it has been taken.
	task automatic send_word(bit [RANGE_W-1:0] r, bit fs);
		int gap;
		bit taken;
		gap = gap_length();
		if (gap > 0) begin
			in_bus.valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_bus.valid        <= 1'b1;
		in_bus.range_sample <= r;
		in_bus.frame_start  <= fs;
		do begin
			@(negedge clk);
			taken = in_bus.ready;
			@(posedge clk);
		end while (!taken);
		scoreboard.note_word(r, fs);
		words_sent++;
	endtask

	task automatic send_random(int count, bit open_frame);
		for (int n = 0; n < count; n++)
			send_word(next_range(), (n == 0 && open_frame) || $urandom_range(0, 299) == 0);
		in_bus.valid <= 1'b0;
	endtask

	// Waits for every expected word, then lets the back end settle.
	task automatic drain();
		do @(negedge clk); while (scoreboard.pending.size() != 0);
		repeat (QUIET_WAIT) @(posedge clk);
	endtask

	task automatic phase(int unsigned thr, int unsigned cols, int count, bit open_frame);
		write_register(CFG_THRESHOLD, CFG_DATA_W'(thr));
		write_register(CFG_COLUMNS, CFG_DATA_W'(cols));
		idle_free = ($urandom_range(0, 3) == 0);
		send_random(count, open_frame);
		drain();
	endtask

	// Result side: random stalls, and one long hold while words keep coming.
	initial begin
		bit held;
		held = 0;
		out_bus.ready <= 1'b0;
		forever begin
			@(posedge clk);
			if (!held && words_sent > 920) begin
				held = 1;
				out_bus.ready <= 1'b0;
				repeat (3000) @(posedge clk);
			end
			out_bus.ready <= idle_free || ($urandom_range(0, 99) < 70) ||
				($urandom_range(0, 99) < 50);
		end
	end

	always @(negedge clk) begin
		if (arst_n && out_bus.valid && out_bus.ready)
			scoreboard.check_word(out_bus.edge_row, out_bus.edge_column, out_bus.edge_score);
	end

	// Stimulus sequence.
	initial begin
		arst_n             <= 1'b0;
		cfg_write          <= 1'b0;
		cfg_index          <= CFG_THRESHOLD;
		cfg_data           <= '0;
		in_bus.valid       <= 1'b0;
		in_bus.range_sample <= '0;
		in_bus.frame_start <= 1'b0;
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		repeat (2) @(posedge clk);

		// Directed: a flat stretch (zero variance), extremes, then a step.
		send_word(16'd0, 1'b1);
		for (int n = 0; n < 17; n++) send_word(16'd0, 1'b0);
		send_word(16'hFFFF, 1'b0);
		send_word(16'd0, 1'b0);
		for (int n = 0; n < 5; n++) send_word(16'hFFFF, 1'b0);
		in_bus.valid <= 1'b0;
		drain();

		// Column register at zero acts as one, so nothing is scored.
		phase(0, 0, 60, 1'b0);
		// Rows one column longer than the shortest that can be scored, then the shortest.
		phase(0, 19, 200, 1'b0);
		phase(0, 18, 60, 1'b0);
		// Mid thresholds.
		phase($urandom_range(0, 200000), 24, 300, 1'b1);
		phase($urandom_range(0, 5000), 40, 250, 1'b0);
		// Oversized column value gives one long row; the long output hold
		// lands in this phase.
		phase(0, 8191, 400, 1'b1);
		// Lowered mid-row: the next word starts a new row.
		phase(31'h7FFF_FFFF, 33, 150, 1'b0);
		phase(50, 4096, 150, 1'b0);
		phase(10, 21, 250, 1'b0);

		if (scoreboard.failures == 0)
			$display("tb_range_row_edge_detector_top: PASS");
		else
			$display("tb_range_row_edge_detector_top: FAIL");
		$finish;
	end

endmodule

### sim.f
+incdir+src
src/rred_pkg.sv
src/rred_if.sv
src/rred_front.sv
src/rred_fifo.sv
src/rred_back.sv
src/range_row_edge_detector_top.sv
sim/tb_range_row_edge_detector_top.sv
